FILE: rtl/mt64_pkg.sv
// Package for the 64-bit Mersenne Twister generator.
// Holds word constants, tempering function and shared types; no dependencies.
package mt64_pkg;

    localparam int Words = 312;
    localparam int Mid = 156;
    localparam int AddrW = 9;
    localparam logic [63:0] Mult = 64'h5851F42D4C957F2D;
    localparam logic [31:0] MultLo = 32'h4C957F2D;
    localparam logic [31:0] MultHi = 32'h5851F42D;
    localparam logic [63:0] TwistMask = 64'hB5026F5AA96619E9;
    localparam logic [63:0] UpperMask = 64'hFFFFFFFF80000000;
    localparam logic [63:0] LowerMask = 64'h000000007FFFFFFF;
    localparam logic [63:0] TemperD = 64'h5555555555555555;
    localparam logic [63:0] TemperB = 64'h71D67FFFEDA60000;
    localparam logic [63:0] TemperC = 64'hFFF7EEE000000000;
    localparam logic [63:0] DefaultSeed = 64'd5489;
    localparam logic [AddrW-1:0] LastAddr = AddrW'(Words - 1);
    localparam logic [AddrW-1:0] MidAddr = AddrW'(Mid);

    // One queued request between the front and the back.
    typedef struct packed {
        logic [63:0] bound;
        logic        raw;
    } req_t;

    // Temper one state word.
    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] y;
        y = w;
        y = y ^ ((y >> 29) & TemperD);
        y = y ^ ((y << 17) & TemperB);
        y = y ^ ((y << 37) & TemperC);
        y = y ^ (y >> 43);
        return y;
    endfunction

    // Wrap an index onto the state ring.
    function automatic logic [AddrW-1:0] wrap(input logic [AddrW:0] a);
        logic [AddrW:0] s;
        s = (a >= (AddrW+1)'(Words)) ? a - (AddrW+1)'(Words) : a;
        return s[AddrW-1:0];
    endfunction

endpackage

FILE: rtl/mt64_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module mt64_ram #(
    parameter int Width = 64,
    parameter int Depth = 312
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr_a,
    output logic [Width-1:0]         rdata_a,
    input  logic [$clog2(Depth)-1:0] raddr_b,
    output logic [Width-1:0]         rdata_b
);

    logic [Width-1:0] mem [Depth];

    // Write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/mt64_front.sv
// Front end: accepts requests, classifies them and queues them.
// Depends on mt64_pkg.
module mt64_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [63:0]     bound,
    output logic            q_valid,
    input  logic            q_pop,
    output mt64_pkg::req_t  q_head
);

    mt64_pkg::req_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head = q_reg[rd_reg];

    // Two-entry request queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                q_reg[wr_reg] <= '{bound: bound, raw: (bound == 64'd0)};
                wr_reg <= !wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

FILE: rtl/mt64_divider.sv
// Restoring 64-bit remainder unit, one quotient bit per cycle.
// No dependencies.
module mt64_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] remainder
);

    logic [63:0] num_reg;
    logic [64:0] rem_reg;
    logic [63:0] div_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {rem_reg[63:0], num_reg[63]};
    assign diff = shifted - {1'b0, div_reg};
    assign done = busy_reg && (cnt_reg == 7'd0);
    assign remainder = rem_reg[63:0];

    // One shift-subtract step each cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 7'd64;
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 7'd1;
                num_reg <= {num_reg[62:0], 1'b0};
                rem_reg <= diff[64] ? shifted : diff;
            end
        end
    end

endmodule

FILE: rtl/mt64_back.sv
// Back end: seeding, twisting, drawing, rejection and the modulo.
// Depends on mt64_pkg, mt64_ram and mt64_divider.
module mt64_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [63:0]     cfg_data,
    input  logic            q_valid,
    output logic            q_pop,
    input  mt64_pkg::req_t  q_head,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [63:0]     random_value
);

    typedef enum logic [3:0] {
        S_SEED, S_SEEDMUL, S_IDLE, S_LIMIT, S_LIMWAIT, S_DRAW, S_TW_RD, S_TW_WAIT,
        S_TW_WR, S_RD_WAIT, S_CHECK, S_MOD, S_OUT
    } state_t;

    state_t state_reg;
    logic [8:0]  idx_reg;
    logic [8:0]  pos_reg;
    logic [63:0] prev_reg;
    logic [63:0] prod_reg;
    logic [1:0]  mph_reg;
    logic [63:0] up_reg;
    logic [63:0] limit_reg;
    logic [63:0] word_reg;
    logic [63:0] res_reg;
    logic        out_reg;
    logic        we;
    logic [8:0]  waddr;
    logic [63:0] wdata;
    logic [8:0]  ra;
    logic [8:0]  rb;
    logic [63:0] da;
    logic [63:0] db;
    logic        dstart;
    logic [63:0] ddvd;
    logic        ddone;
    logic [63:0] drem;
    logic [63:0] joined;
    logic [63:0] mixed;
    logic [63:0] tw;
    logic [63:0] seed_x;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] mul_term;

    mt64_ram #(.Width(64), .Depth(mt64_pkg::Words)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .rdata_a(da), .raddr_b(rb), .rdata_b(db)
    );

    mt64_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(ddvd),
        .divisor(q_head.bound), .done(ddone), .remainder(drem)
    );

    assign cfg_ready = (state_reg == S_IDLE) && !q_valid && !out_reg;
    assign out_valid = out_reg;
    assign random_value = res_reg;
    assign tw = mt64_pkg::temper(da);

    // Twist step: word i from words i, i+1 and i+156.
    assign joined = (up_reg & mt64_pkg::UpperMask) | (da & mt64_pkg::LowerMask);
    assign mixed = (joined >> 1) ^ (joined[0] ? mt64_pkg::TwistMask : 64'd0);

    // Seeding product, low 64 bits only, built from three 32 by 32 partial products
    // in turn with one shared multiplier.
    assign seed_x = prev_reg ^ (prev_reg >> 62);

    always_comb
    begin
        mul_a = seed_x[31:0];
        mul_b = mt64_pkg::MultLo;
        case (mph_reg)
            2'd1: begin
                mul_b = mt64_pkg::MultHi;
            end
            2'd2: begin
                mul_a = seed_x[63:32];
            end
            default: begin
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
        mul_term = (mph_reg == 2'd0) ? mul_p : {mul_p[31:0], 32'd0};
    end

    // RAM addresses, write port and divider requests.
    always_comb
    begin
        ra = pos_reg;
        rb = mt64_pkg::wrap({1'b0, idx_reg} + 10'(mt64_pkg::Mid));
        we = 1'b0;
        waddr = idx_reg;
        wdata = prev_reg;
        dstart = 1'b0;
        ddvd = 64'd0;
        case (state_reg)
            S_SEED: begin
                we = 1'b1;
            end
            S_TW_RD: begin
                ra = idx_reg;
            end
            S_TW_WAIT: begin
                ra = mt64_pkg::wrap({1'b0, idx_reg} + 10'd1);
            end
            S_TW_WR: begin
                ra = mt64_pkg::wrap({1'b0, idx_reg} + 10'd1);
                we = 1'b1;
                wdata = db ^ mixed;
            end
            S_LIMIT: begin
                dstart = 1'b1;
                ddvd = '1;
            end
            S_CHECK: begin
                ra = pos_reg;
                dstart = !q_head.raw && (tw < limit_reg);
                ddvd = tw;
            end
            default: begin
            end
        endcase
    end

    assign q_pop = (state_reg == S_OUT) && !out_reg;

    // Sequencer and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SEED;
            idx_reg <= 9'd0;
            pos_reg <= 9'(mt64_pkg::Words);
            prev_reg <= mt64_pkg::DefaultSeed;
            mph_reg <= 2'd0;
            out_reg <= 1'b0;
        end
        else
        begin
            if (out_reg && !out_stall)
            begin
                out_reg <= 1'b0;
            end
            case (state_reg)
                S_SEED: begin
                    // Word idx written; start forming the next one.
                    if (idx_reg == mt64_pkg::LastAddr)
                    begin
                        pos_reg <= 9'(mt64_pkg::Words);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        prod_reg <= 64'(idx_reg + 9'd1);
                        mph_reg <= 2'd0;
                        state_reg <= S_SEEDMUL;
                    end
                end
                S_SEEDMUL: begin
                    // Accumulate one partial product per cycle.
                    if (mph_reg == 2'd2)
                    begin
                        prev_reg <= prod_reg + mul_term;
                        idx_reg <= idx_reg + 9'd1;
                        state_reg <= S_SEED;
                    end
                    else
                    begin
                        prod_reg <= prod_reg + mul_term;
                        mph_reg <= mph_reg + 2'd1;
                    end
                end
                S_IDLE: begin
                    if (cfg_valid && cfg_ready)
                    begin
                        prev_reg <= cfg_data;
                        idx_reg <= 9'd0;
                        state_reg <= S_SEED;
                    end
                    else if (q_valid && !out_reg)
                    begin
                        limit_reg <= '1;
                        state_reg <= q_head.raw ? S_DRAW : S_LIMIT;
                    end
                end
                S_LIMIT: begin
                    state_reg <= S_LIMWAIT;
                end
                S_LIMWAIT: begin
                    // The limit is all ones less the remainder of all ones.
                    if (ddone)
                    begin
                        limit_reg <= ~drem;
                        state_reg <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    if (pos_reg == 9'(mt64_pkg::Words))
                    begin
                        idx_reg <= 9'd0;
                        state_reg <= S_TW_RD;
                    end
                    else
                    begin
                        state_reg <= S_RD_WAIT;
                    end
                end
                S_TW_RD: begin
                    pos_reg <= idx_reg;
                    state_reg <= S_TW_WAIT;
                end
                S_TW_WAIT: begin
                    up_reg <= da;
                    state_reg <= S_TW_WR;
                end
                S_TW_WR: begin
                    if (idx_reg == mt64_pkg::LastAddr)
                    begin
                        pos_reg <= 9'd0;
                        state_reg <= S_DRAW;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 9'd1;
                        state_reg <= S_TW_RD;
                    end
                end
                S_RD_WAIT: begin
                    // Read data arrives next cycle; pos_reg still addresses it.
                    state_reg <= S_CHECK;
                    word_reg <= 64'd0;
                end
                S_CHECK: begin
                    word_reg <= tw;
                    state_reg <= S_MOD;
                    pos_reg <= pos_reg + 9'd1;
                end
                S_MOD: begin
                    // Raw word, rejected draw, or wait for the residue.
                    if (q_head.raw)
                    begin
                        res_reg <= word_reg;
                        state_reg <= S_OUT;
                    end
                    else if (word_reg >= limit_reg)
                    begin
                        state_reg <= S_DRAW;
                    end
                    else if (ddone)
                    begin
                        res_reg <= drem;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!out_reg)
                    begin
                        out_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/mt64_random_generator_top.sv
// Top level of the 64-bit Mersenne Twister generator with bounded output.
// Depends on mt64_pkg, mt64_front and mt64_back.
//
// Each item asks for one 64-bit random word; bound zero returns the tempered word,
// otherwise an unbiased residue below bound. A bounded item first forms its
// limit and then draws a word and takes its modulo, both with the
// one-bit-per-cycle remainder unit; a rejected draw is drawn again. Every 312 words
// a twist pass over the state memory runs before the next draw. After reset and
// after each seed write a seeding pass runs, during which items queue.
module mt64_random_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] bound,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] random_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    logic           q_valid;
    logic           q_pop;
    mt64_pkg::req_t q_head;

    mt64_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .bound(bound), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
    );

    mt64_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
        .out_valid(out_valid), .out_stall(out_stall), .random_value(random_value)
    );

    // A result is only raised while a request is queued.
    a_out_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_valid))
        else $error("result without request");

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(random_value))
        else $error("result changed while stalled");

    // No seed write is taken while a request is queued.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !q_valid)
        else $error("seed port ready while busy");

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for the 64-bit Mersenne Twister generator with bounded output.
// Depends on mt64_pkg and mt64_random_generator_top; predicts each random value internally.
module tb_top;

    localparam logic [63:0] AllOnes = 64'hFFFFFFFFFFFFFFFF;
    localparam int SettleCycles = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] bound;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] random_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;
    logic        in_taken;

    // Predictor state: the twister ring and its read position.
    logic [63:0] ring [0:mt64_pkg::Words-1];
    int          ring_pos;

    logic [63:0] pending_bounds [$];
    logic [63:0] expected_values [$];
    int          errors;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_off_cycles;

    mt64_random_generator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .bound        (bound),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Reload the ring from a seed.
    task automatic seed_ring(input logic [63:0] s);
        ring[0] = s;
        for (int i = 1; i < mt64_pkg::Words; i++)
            ring[i] = mt64_pkg::Mult * (ring[i-1] ^ (ring[i-1] >> 62)) + 64'(i);
        ring_pos = mt64_pkg::Words;
    endtask

    // Draw one tempered word, twisting the ring when it is exhausted.
    function automatic logic [63:0] next_tempered();
        logic [63:0] joined;
        logic [63:0] mixed;
        logic [63:0] y;
        if (ring_pos >= mt64_pkg::Words)
        begin
            for (int i = 0; i < mt64_pkg::Words; i++)
            begin
                joined = (ring[i] & mt64_pkg::UpperMask) |
                         (ring[(i + 1) % mt64_pkg::Words] & mt64_pkg::LowerMask);
                mixed = joined >> 1;
                if (joined[0])
                    mixed = mixed ^ mt64_pkg::TwistMask;
                ring[i] = ring[(i + mt64_pkg::Mid) % mt64_pkg::Words] ^ mixed;
            end
            ring_pos = 0;
        end
        y = ring[ring_pos];
        ring_pos++;
        y = y ^ ((y >> 29) & mt64_pkg::TemperD);
        y = y ^ ((y << 17) & mt64_pkg::TemperB);
        y = y ^ ((y << 37) & mt64_pkg::TemperC);
        y = y ^ (y >> 43);
        return y;
    endfunction

    // Unbiased residue below the bound, or the raw word for bound zero.
    function automatic logic [63:0] bounded_value(input logic [63:0] b);
        logic [63:0] limit;
        logic [63:0] r;
        if (b == 64'd0)
            return next_tempered();
        limit = AllOnes - (AllOnes % b);
        do
            r = next_tempered();
        while (r >= limit);
        return r % b;
    endfunction

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: offers items from the pending queue at the falling edge.
    always @(negedge clk)
    begin
        if (in_taken)
            void'(pending_bounds.pop_front());
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            in_valid <= 1'b1;
        else if (pending_bounds.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
        begin
            in_valid <= 1'b1;
            bound <= pending_bounds[0];
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver stall, with an optional long hold-off counted here.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    // Predict on acceptance of an item, check on acceptance of a result.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_values.push_back(bounded_value(bound));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_values.size() == 0)
            begin
                $display("%0t: unexpected item, actual %h", $time, random_value);
                errors++;
            end
            else
            begin
                if (random_value !== expected_values[0])
                begin
                    $display("%0t: random_value mismatch, expected %h actual %h",
                             $time, expected_values[0], random_value);
                    errors++;
                end
                void'(expected_values.pop_front());
            end
        end
    end

    task automatic wait_drained();
        while (pending_bounds.size() > 0 || in_valid || expected_values.size() > 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= s;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        seed_ring(s);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random bound: zero, small values including one, and large values.
    function automatic logic [63:0] random_bound();
        case ($urandom_range(5, 0))
            0: return 64'd0;
            1: return 64'($urandom_range(16, 1));
            2: return {$urandom, $urandom};
            3: return {1'b1, 31'($urandom), $urandom};
            4: return AllOnes - 64'($urandom_range(3, 0));
            default: return 64'($urandom_range(1000, 1));
        endcase
    endfunction

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
            pending_bounds.push_back(random_bound());
        wait_drained();
    endtask

    // Stimulus.
    initial
    begin
        in_valid = 1'b0;
        in_taken = 1'b0;
        bound = 64'd0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 64'd0;
        errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        seed_ring(mt64_pkg::DefaultSeed);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items on the reset seed: extremes and bound one.
        pending_bounds.push_back(64'd0);
        pending_bounds.push_back(64'd1);
        pending_bounds.push_back(64'd2);
        pending_bounds.push_back(64'd3);
        pending_bounds.push_back(AllOnes);
        pending_bounds.push_back(AllOnes - 64'd1);
        pending_bounds.push_back(64'h8000000000000000);
        pending_bounds.push_back(64'h8000000000000001);
        pending_bounds.push_back(64'h5555555555555555);
        pending_bounds.push_back(64'hAAAAAAAAAAAAAAAA);
        pending_bounds.push_back(64'd0);
        wait_drained();

        // Seed zero, all ones, then a random seed.
        write_seed(64'd0);
        run_phase(40, 0, 0);
        write_seed(AllOnes);
        run_phase(40, 0, 0);
        write_seed({$urandom, $urandom});

        // Long receiver hold-off while the sender keeps offering items.
        hold_off_cycles = 3000;
        run_phase(60, 0, 0);

        run_phase(400, 0, 0);
        run_phase(300, 83, 0);
        write_seed({$urandom, $urandom});
        run_phase(300, 0, 83);
        run_phase(300, 6, 6);
        write_seed(mt64_pkg::DefaultSeed);
        run_phase(100, 50, 50);

        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
